[hw/rtl/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ATCD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ATCD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/atcd_pkg.sv]
package atcd_pkg;

    localparam int KW_COUNT = 11;

    // keyword slots
    localparam int KW_RESET   = 0;
    localparam int KW_EN      = 1;
    localparam int KW_DIS     = 2;
    localparam int KW_OPEN    = 3;
    localparam int KW_CLOSE   = 4;
    localparam int KW_MOVETO  = 5;
    localparam int KW_M1      = 6;
    localparam int KW_M2      = 7;
    localparam int KW_M3      = 8;
    localparam int KW_WAIT_S  = 9;
    localparam int KW_WAIT_MS = 10;

    localparam logic [KW_COUNT-1:0] KW_ALL   = 11'h7FF;
    localparam logic [KW_COUNT-1:0] KW_ALONE = 11'h01F;
    localparam logic [KW_COUNT-1:0] KW_ARGS  = 11'h7E0;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_RESET   = 3'd1;
    localparam logic [2:0] CMD_ENABLE  = 3'd2;
    localparam logic [2:0] CMD_DISABLE = 3'd3;
    localparam logic [2:0] CMD_SERVO   = 3'd4;
    localparam logic [2:0] CMD_MOVETO  = 3'd5;
    localparam logic [2:0] CMD_ROTATE  = 3'd6;
    localparam logic [2:0] CMD_WAIT    = 3'd7;

    localparam logic [7:0]  ANGLE_OPEN   = 8'd175;
    localparam logic [7:0]  ANGLE_CLOSE  = 8'd92;
    localparam logic [24:0] MS_PER_SEC   = 25'd1000;
    localparam logic [24:0] WAIT_MAX_MS  = 25'd32767000;
    localparam logic [14:0] AMOUNT_MAX   = 15'd32767;

    localparam logic [1:0] TOK_ACTION = 2'd0;
    localparam logic [1:0] TOK_FIRST  = 2'd1;
    localparam logic [1:0] TOK_LAST   = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_command;
    } cmd_beat_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  command;
        logic [1:0]  motor_select;
        logic [7:0]  servo_angle;
        logic [14:0] rotate_amount;
        logic        counterclockwise;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
        logic [15:0] coord_z;
        logic [24:0] wait_millis;
    } result_t;

    // parser state as it stands after the final byte of a command
    typedef struct packed {
        logic [1:0]          tok;
        logic [KW_COUNT-1:0] cand;
        logic [4:0]          alone;
        logic                bad;
        logic                missing;
        logic                minus;
        logic                amount_small;
        logic [14:0]         amount;
        logic [15:0]         x;
        logic [15:0]         y;
        logic [15:0]         z;
    } snap_t;

    function automatic logic [2:0] kw_len(input int k);
        logic [2:0] len;
        case (k)
            KW_RESET:   len = 3'd5;
            KW_EN:      len = 3'd2;
            KW_DIS:     len = 3'd3;
            KW_OPEN:    len = 3'd4;
            KW_CLOSE:   len = 3'd5;
            KW_MOVETO:  len = 3'd6;
            KW_M1:      len = 3'd2;
            KW_M2:      len = 3'd2;
            KW_M3:      len = 3'd2;
            KW_WAIT_S:  len = 3'd6;
            KW_WAIT_MS: len = 3'd7;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    // first character sits in the top byte
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
        logic [63:0] w;
        case (k)
            KW_RESET:   w = {"RESET", 24'h0};
            KW_EN:      w = {"EN", 48'h0};
            KW_DIS:     w = {"DIS", 40'h0};
            KW_OPEN:    w = {"OPEN", 32'h0};
            KW_CLOSE:   w = {"CLOSE", 24'h0};
            KW_MOVETO:  w = {"MOVETO", 16'h0};
            KW_M1:      w = {"M1", 48'h0};
            KW_M2:      w = {"M2", 48'h0};
            KW_M3:      w = {"M3", 48'h0};
            KW_WAIT_S:  w = {"WAIT_S", 16'h0};
            KW_WAIT_MS: w = {"WAIT_MS", 8'h0};
            default:    w = 64'h0;
        endcase
        return w[63 - 8 * int'(pos) -: 8];
    endfunction

endpackage

[hw/rtl/arm_text_command_decoder.sv]
// Text command decoder: takes one character per beat on cmd, with end_of_command
// on the final character, and gives one decoded result beat on res per command.
// A new character can be taken every cycle; each beat is registered, then the
// parser step (keyword match plus saturating decimal accumulate) runs from
// that register into the result register, so a final character passes the
// input register, then the result register. The input register only holds when
// it carries a final character and the result register is full and stalled.
// Syntax errors give status 1 with every other field zero.
module arm_text_command_decoder #(
    parameter int NUMBER_WIDTH = 16,
    parameter int ACTION_CHARS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  atcd_pkg::cmd_beat_t cmd_data,
    output logic                res_valid,
    input  logic                res_stall,
    output atcd_pkg::result_t   res_data
);

    `include "assert_macros.svh"

    logic                in_valid_reg;
    logic                in_valid_next;
    atcd_pkg::cmd_beat_t in_beat_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    atcd_pkg::result_t   out_data_reg;
    logic                cmd_take;
    logic                advance;
    logic                res_take;
    atcd_pkg::snap_t     snap;
    atcd_pkg::result_t   result;

    // a beat without end_of_command never needs the result slot
    assign advance = in_valid_reg &&
                     (!in_beat_reg.end_of_command || !out_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign res_take  = out_valid_reg && !res_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && in_beat_reg.end_of_command)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_beat_reg <= cmd_data;
        end
        if (advance && in_beat_reg.end_of_command)
        begin
            out_data_reg <= result;
        end
    end

    atcd_parser #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .ACTION_CHARS (ACTION_CHARS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .beat    (in_beat_reg),
        .snap    (snap)
    );

    atcd_decode u_decode (
        .snap (snap),
        .res  (result)
    );

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    `ATCD_ASSERT_NXT(a_last_gives_result, clk, rst_n, advance && in_beat_reg.end_of_command, res_valid, "final beat did not produce a result")
    `ATCD_ASSERT_IMP(a_error_is_blank, clk, rst_n, res_valid && res_data.status, res_data.command == atcd_pkg::CMD_NONE && res_data.coord_x == 16'd0 && res_data.wait_millis == 25'd0, "error result carries data")
    `ATCD_ASSERT_IMP(a_motor_only_rotate, clk, rst_n, res_valid && res_data.command != atcd_pkg::CMD_ROTATE, res_data.motor_select == 2'd0 && !res_data.counterclockwise, "motor fields set outside rotate")
    `ATCD_ASSERT_IMP(a_wait_range, clk, rst_n, res_valid, res_data.wait_millis <= atcd_pkg::WAIT_MAX_MS, "wait time out of range")

endmodule

[hw/rtl/atcd_parser.sv]
module atcd_parser #(
    parameter int NUMBER_WIDTH = 16,
    parameter int ACTION_CHARS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  atcd_pkg::cmd_beat_t beat,
    output atcd_pkg::snap_t     snap
);

    localparam int PW = $clog2(ACTION_CHARS + 1);
    localparam int AW = (NUMBER_WIDTH > 16) ? NUMBER_WIDTH : 16;
    localparam int KC = atcd_pkg::KW_COUNT;

    logic [KC-1:0]           cand_reg, cand_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [1:0]              tok_reg, tok_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic                    bad_reg, bad_next;
    logic                    minus_reg, minus_next;
    logic [NUMBER_WIDTH-1:0] acc_reg, acc_next;
    logic [NUMBER_WIDTH-1:0] sx_reg, sx_next;
    logic [NUMBER_WIDTH-1:0] sy_reg, sy_next;

    logic                    is_space;
    logic                    is_digit;
    logic                    missing_reg;
    logic                    missing_next;
    logic [NUMBER_WIDTH+3:0] times_ten;
    logic [KC-1:0]           len_hits_reg;
    logic [KC-1:0]           len_hits_next;
    logic [AW-1:0]           acc_ext;

    function automatic logic [15:0] cap16(input logic [NUMBER_WIDTH-1:0] v);
        logic [AW-1:0] e;
        e = AW'(v);
        return (e > AW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
    endfunction

    assign is_space = (beat.char_code == atcd_pkg::CHAR_SPACE);
    assign is_digit = (beat.char_code >= atcd_pkg::CHAR_0) &&
                      (beat.char_code <= atcd_pkg::CHAR_9);
    // a number token with no digit in it
    assign missing_reg  = (cnt_reg == 5'd0) || (minus_reg && cnt_reg == 5'd1);
    assign missing_next = (cnt_next == 5'd0) || (minus_next && cnt_next == 5'd1);

    assign times_ten = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) +
                       (NUMBER_WIDTH + 4)'(beat.char_code[3:0]);

    always_comb
    begin
        for (int k = 0; k < KC; k++)
        begin
            len_hits_reg[k]  = (pos_reg == PW'(atcd_pkg::kw_len(k)));
            len_hits_next[k] = (pos_next == PW'(atcd_pkg::kw_len(k)));
        end
    end

    always_comb
    begin
        cand_next  = cand_reg;
        pos_next   = pos_reg;
        tok_next   = tok_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        minus_next = minus_reg;
        acc_next   = acc_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        if (tok_reg == atcd_pkg::TOK_ACTION)
        begin
            if (is_space && !beat.end_of_command)
            begin
                cand_next  = cand_reg & len_hits_reg & atcd_pkg::KW_ARGS;
                tok_next   = atcd_pkg::TOK_FIRST;
                cnt_next   = 5'd0;
                minus_next = 1'b0;
                acc_next   = '0;
            end
            else
            begin
                for (int k = 0; k < KC; k++)
                begin
                    if ((pos_reg >= PW'(atcd_pkg::kw_len(k))) ||
                        (atcd_pkg::kw_char(k, pos_reg[2:0]) != beat.char_code))
                    begin
                        cand_next[k] = 1'b0;
                    end
                end
                if (pos_reg < PW'(ACTION_CHARS))
                begin
                    pos_next = pos_reg + PW'(1);
                end
            end
        end
        else
        begin
            if (is_space && !beat.end_of_command && cand_reg[atcd_pkg::KW_MOVETO] &&
                tok_reg != atcd_pkg::TOK_LAST)
            begin
                if (missing_reg)
                begin
                    bad_next = 1'b1;
                end
                if (tok_reg == atcd_pkg::TOK_FIRST)
                begin
                    sx_next = acc_reg;
                end
                else
                begin
                    sy_next = acc_reg;
                end
                tok_next   = tok_reg + 2'd1;
                cnt_next   = 5'd0;
                minus_next = 1'b0;
                acc_next   = '0;
            end
            else
            begin
                if (beat.char_code == atcd_pkg::CHAR_MINUS && cnt_reg == 5'd0)
                begin
                    minus_next = 1'b1;
                end
                else if (is_digit)
                begin
                    // saturate at all ones
                    if (times_ten > {4'b0, {NUMBER_WIDTH{1'b1}}})
                    begin
                        acc_next = {NUMBER_WIDTH{1'b1}};
                    end
                    else
                    begin
                        acc_next = times_ten[NUMBER_WIDTH-1:0];
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
                if (cnt_reg != 5'd31)
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
        end
    end

    assign acc_ext = AW'(acc_next);

    always_comb
    begin
        snap              = '0;
        snap.tok          = tok_next;
        snap.cand         = cand_next;
        snap.alone        = 5'(len_hits_next & cand_next & atcd_pkg::KW_ALONE);
        snap.bad          = bad_next;
        snap.missing      = missing_next;
        snap.minus        = minus_next;
        snap.amount_small = (acc_ext <= AW'(atcd_pkg::AMOUNT_MAX));
        snap.amount       = acc_ext[14:0];
        snap.x            = cap16(sx_next);
        snap.y            = cap16(sy_next);
        snap.z            = cap16(acc_next);
    end

    // the final byte of a command puts the parser back to its start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg  <= atcd_pkg::KW_ALL;
            pos_reg   <= '0;
            tok_reg   <= atcd_pkg::TOK_ACTION;
            cnt_reg   <= 5'd0;
            bad_reg   <= 1'b0;
            minus_reg <= 1'b0;
            acc_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
        end
        else if (step_en)
        begin
            if (beat.end_of_command)
            begin
                cand_reg  <= atcd_pkg::KW_ALL;
                pos_reg   <= '0;
                tok_reg   <= atcd_pkg::TOK_ACTION;
                cnt_reg   <= 5'd0;
                bad_reg   <= 1'b0;
                minus_reg <= 1'b0;
                acc_reg   <= '0;
                sx_reg    <= '0;
                sy_reg    <= '0;
            end
            else
            begin
                cand_reg  <= cand_next;
                pos_reg   <= pos_next;
                tok_reg   <= tok_next;
                cnt_reg   <= cnt_next;
                bad_reg   <= bad_next;
                minus_reg <= minus_next;
                acc_reg   <= acc_next;
                sx_reg    <= sx_next;
                sy_reg    <= sy_next;
            end
        end
    end

endmodule

[hw/rtl/atcd_decode.sv]
module atcd_decode (
    input  atcd_pkg::snap_t   snap,
    output atcd_pkg::result_t res
);

    logic num_ok;

    assign num_ok = !snap.bad && !snap.missing;

    always_comb
    begin
        res        = '0;
        res.status = 1'b1;
        if (snap.tok == atcd_pkg::TOK_ACTION)
        begin
            if (snap.alone[atcd_pkg::KW_RESET])
            begin
                res.status  = 1'b0;
                res.command = atcd_pkg::CMD_RESET;
            end
            else if (snap.alone[atcd_pkg::KW_EN])
            begin
                res.status  = 1'b0;
                res.command = atcd_pkg::CMD_ENABLE;
            end
            else if (snap.alone[atcd_pkg::KW_DIS])
            begin
                res.status  = 1'b0;
                res.command = atcd_pkg::CMD_DISABLE;
            end
            else if (snap.alone[atcd_pkg::KW_OPEN])
            begin
                res.status      = 1'b0;
                res.command     = atcd_pkg::CMD_SERVO;
                res.servo_angle = atcd_pkg::ANGLE_OPEN;
            end
            else if (snap.alone[atcd_pkg::KW_CLOSE])
            begin
                res.status      = 1'b0;
                res.command     = atcd_pkg::CMD_SERVO;
                res.servo_angle = atcd_pkg::ANGLE_CLOSE;
            end
        end
        else if (snap.cand[atcd_pkg::KW_MOVETO])
        begin
            if (snap.tok == atcd_pkg::TOK_LAST && num_ok)
            begin
                res.status  = 1'b0;
                res.command = atcd_pkg::CMD_MOVETO;
                res.coord_x = snap.x;
                res.coord_y = snap.y;
                res.coord_z = snap.z;
            end
        end
        else if (snap.cand != '0)
        begin
            if (num_ok && snap.amount_small)
            begin
                res.status = 1'b0;
                if (snap.cand[atcd_pkg::KW_M1] || snap.cand[atcd_pkg::KW_M2] ||
                    snap.cand[atcd_pkg::KW_M3])
                begin
                    res.command          = atcd_pkg::CMD_ROTATE;
                    res.rotate_amount    = snap.amount;
                    res.counterclockwise = snap.minus;
                    if (snap.cand[atcd_pkg::KW_M3])
                    begin
                        res.motor_select = 2'd3;
                    end
                    else if (snap.cand[atcd_pkg::KW_M2])
                    begin
                        res.motor_select = 2'd2;
                    end
                    else
                    begin
                        res.motor_select = 2'd1;
                    end
                end
                if (snap.cand[atcd_pkg::KW_WAIT_S])
                begin
                    res.command     = atcd_pkg::CMD_WAIT;
                    res.wait_millis = 25'(snap.amount) * atcd_pkg::MS_PER_SEC;
                end
                if (snap.cand[atcd_pkg::KW_WAIT_MS])
                begin
                    res.command     = atcd_pkg::CMD_WAIT;
                    res.wait_millis = 25'(snap.amount);
                end
            end
        end
    end

endmodule
